// ----- rtl/core/dqtu_pkg.sv -----
// shared types, constants and register codes for the double q-table update block
package dqtu_pkg;

  localparam int ROWS_DEF    = 1024;
  localparam int ACTIONS_DEF = 3;

  localparam int STATE_W = 10;
  localparam int ACT_W   = 2;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int LIM_W   = 11;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // shared multiplier: signed 33 x signed 17
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [FRAC_W-1:0] LEARN_RATE_RST  = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST    = 16'd58982;
  localparam logic [LIM_W-1:0]  ROWS_IN_USE_RST = 11'd1024;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_LEARN_RATE  = 2'd0,
    REG_DISCOUNT    = 2'd1,
    REG_ROWS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAC_W-1:0] learn_rate;
    logic [FRAC_W-1:0] discount;
    logic [LIM_W-1:0]  rows_in_use;
  } cfg_regs_t;

  typedef struct packed {
    logic [STATE_W-1:0]      state_index;
    logic [ACT_W-1:0]        taken_action;
    logic signed [VAL_W-1:0] reward_value;
    logic                    table_pick;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] updated_value;
    logic [ACT_W-1:0]        next_greedy_action;
    logic                    range_error;
  } out_item_t;

endpackage

// ----- rtl/core/dqtu_mul.sv -----
// shared signed multiplier with registered product
module dqtu_mul
  import dqtu_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(op_a) * MUL_P_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- rtl/core/dqtu_table.sv -----
// single-port-write, single-port-read action-value store with registered read
module dqtu_table
  import dqtu_pkg::*;
#(
  parameter int DEPTH  = ROWS_DEF * ACTIONS_DEF,
  parameter int ADDR_W = $clog2(ROWS_DEF * ACTIONS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [VAL_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [VAL_W-1:0]  rd_data_r
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/dqtu_cfg.sv -----
// apb-style configuration registers: learning rate, discount, rows in use
module dqtu_cfg
  import dqtu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  cfg_reg_t  reg_sel;

  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign regs    = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_LEARN_RATE:  regs_nxt.learn_rate  = pwdata[FRAC_W-1:0];
        REG_DISCOUNT:    regs_nxt.discount    = pwdata[FRAC_W-1:0];
        REG_ROWS_IN_USE: regs_nxt.rows_in_use = pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LEARN_RATE:  prdata = {(CFG_DATA_W-FRAC_W)'(0), regs_r.learn_rate};
      REG_DISCOUNT:    prdata = {(CFG_DATA_W-FRAC_W)'(0), regs_r.discount};
      REG_ROWS_IN_USE: prdata = {(CFG_DATA_W-LIM_W)'(0), regs_r.rows_in_use};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.learn_rate  <= LEARN_RATE_RST;
      regs_r.discount    <= DISCOUNT_RST;
      regs_r.rows_in_use <= ROWS_IN_USE_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ----- rtl/core/double_q_table_update.sv -----
// top level: sequencer, two action-value stores and shared multiplier for double q update
// an accepted item passes through the serial row scan, the old-entry read and three
// multiplier passes (gamma, alpha low slice, alpha high slice) before out_valid
// a new item is taken only after the result is handed over; an out-of-range item skips to hand-over
// reset (rst_n, synchronous): registers to defaults, then a clearing pass over all ROWS*ACTIONS
// entries zeroes both stores while in_stall stays high
module double_q_table_update
  import dqtu_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int ACTIONS = ACTIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = ROWS * ACTIONS;
  localparam int AD_W  = $clog2(DEPTH);
  localparam int CNT_W = $clog2(ACTIONS + 1);
  localparam int IDX_W = $clog2(ACTIONS);
  localparam int TD_W  = 49;   // reward*2^16 + gamma term - old entry
  localparam int LO_W  = 24;   // low slice of td for the split alpha multiply
  localparam int HI_W  = TD_W - LO_W;
  localparam int LOP_W = LO_W + FRAC_W;
  localparam int HIP_W = HI_W + FRAC_W;
  localparam int SUM_W = HIP_W + LO_W + 1;
  localparam int STP_W = SUM_W - FRAC_W;
  localparam int NV_W  = STP_W + 1;

  // one-hot sequencer states
  typedef enum logic [9:0] {
    ST_CLEAR = 10'b00_0000_0001,  // zeroing sweep after reset
    ST_IDLE  = 10'b00_0000_0010,  // ready for a transaction
    ST_SCAN  = 10'b00_0000_0100,  // read next row, one action a cycle
    ST_CUR   = 10'b00_0000_1000,  // old entry arrives, gamma multiply issued
    ST_TD    = 10'b00_0001_0000,  // form temporal difference
    ST_MLO   = 10'b00_0010_0000,  // alpha times low slice of td
    ST_MHI   = 10'b00_0100_0000,  // alpha times high slice of td
    ST_ACC   = 10'b00_1000_0000,  // join partial products, floor by 2^16
    ST_SAT   = 10'b01_0000_0000,  // add step, saturate
    ST_FIN   = 10'b10_0000_0000   // write back and hand over result
  } state_t;

  cfg_regs_t cfg;

  state_t state_r, state_nxt;
  logic [AD_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers, no reset
  in_item_t                 item_r, item_nxt;
  logic                     err_r, err_nxt;
  logic [AD_W-1:0]          nxt_base_r, nxt_base_nxt;
  logic [AD_W-1:0]          cur_addr_r, cur_addr_nxt;
  logic signed [VAL_W-1:0]  best_m_r, best_m_nxt;    // best of the updated store
  logic signed [VAL_W-1:0]  best_o_r, best_o_nxt;    // other store at that action
  logic signed [VAL_W:0]    best_s_r, best_s_nxt;    // best summed value
  logic [IDX_W-1:0]         gs_r, gs_nxt;
  logic signed [VAL_W-1:0]  cur_r, cur_nxt;
  logic signed [TD_W-1:0]   base_r, base_nxt;
  logic signed [TD_W-1:0]   td_r, td_nxt;
  logic [LOP_W-1:0]         acc_lo_r, acc_lo_nxt;
  logic signed [STP_W-1:0]  step_r, step_nxt;
  logic signed [VAL_W-1:0]  nv_r, nv_nxt;
  out_item_t                out_r, out_nxt;

  // store and multiplier hookup
  logic [VAL_W-1:0]          rd0, rd1;
  logic signed [VAL_W-1:0]   rd_mine, rd_other;
  logic [AD_W-1:0]           rd_addr, wr_addr;
  logic [VAL_W-1:0]          wr_data;
  logic                      wr0, wr1;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic accept;
  logic fire;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign fire      = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd_mine  = item_r.table_pick ? rd1 : rd0;
  assign rd_other = item_r.table_pick ? rd0 : rd1;

  dqtu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  dqtu_table #(.DEPTH(DEPTH), .ADDR_W(AD_W)) u_first (
    .clk       (clk),
    .wr_en     (wr0),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd0)
  );

  dqtu_table #(.DEPTH(DEPTH), .ADDR_W(AD_W)) u_second (
    .clk       (clk),
    .wr_en     (wr1),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd1)
  );

  dqtu_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // read address: next row during the scan, then the entry to update
  always_comb begin
    if (state_r == ST_SCAN && cnt_r < CNT_W'(ACTIONS)) begin
      rd_addr = nxt_base_r + AD_W'(cnt_r);
    end else begin
      rd_addr = cur_addr_r;
    end
  end

  // write port: zeroing sweep or write-back of the new entry
  always_comb begin
    wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : cur_addr_r;
    wr_data = (state_r == ST_CLEAR) ? '0 : nv_r;
    wr0     = (state_r == ST_CLEAR) || (fire && !err_r && !item_r.table_pick);
    wr1     = (state_r == ST_CLEAR) || (fire && !err_r && item_r.table_pick);
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (state_r)
      ST_CUR: begin
        mul_a = MUL_A_W'(best_o_r);
        mul_b = $signed({1'b0, cfg.discount});
      end
      ST_MLO: begin
        mul_a = $signed({(MUL_A_W-LO_W)'(0), td_r[LO_W-1:0]});
        mul_b = $signed({1'b0, cfg.learn_rate});
      end
      ST_MHI: begin
        mul_a = MUL_A_W'($signed(td_r[TD_W-1:LO_W]));
        mul_b = $signed({1'b0, cfg.learn_rate});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer and datapath
  always_comb begin
    logic                    bad;
    logic [IDX_W-1:0]        j;
    logic signed [VAL_W:0]   vsum;
    logic signed [SUM_W-1:0] sum;
    logic signed [NV_W-1:0]  nv_full;

    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    err_nxt       = err_r;
    nxt_base_nxt  = nxt_base_r;
    cur_addr_nxt  = cur_addr_r;
    best_m_nxt    = best_m_r;
    best_o_nxt    = best_o_r;
    best_s_nxt    = best_s_r;
    gs_nxt        = gs_r;
    cur_nxt       = cur_r;
    base_nxt      = base_r;
    td_nxt        = td_r;
    acc_lo_nxt    = acc_lo_r;
    step_nxt      = step_r;
    nv_nxt        = nv_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    // no successor row, or action past the table width
    bad = ({1'b0, in_data.state_index} + LIM_W'(1) >= cfg.rows_in_use)
       || (32'(in_data.state_index) + 32'd1 >= 32'(ROWS))
       || (32'(in_data.taken_action) >= 32'(ACTIONS));

    j       = IDX_W'(cnt_r - CNT_W'(1));
    vsum    = $signed({rd0[VAL_W-1], rd0}) + $signed({rd1[VAL_W-1], rd1});
    sum     = $signed({prod[HIP_W-1:0], LO_W'(0)}) + $signed({(SUM_W-LOP_W)'(0), acc_lo_r});
    nv_full = NV_W'(cur_r) + NV_W'(step_r);

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AD_W'(1);
        if (clr_addr_r == AD_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          item_nxt     = in_data;
          err_nxt      = bad;
          cnt_nxt      = '0;
          nxt_base_nxt = AD_W'((32'(in_data.state_index) + 32'd1) * ACTIONS);
          cur_addr_nxt = AD_W'(32'(in_data.state_index) * ACTIONS
                               + 32'(in_data.taken_action));
          state_nxt    = bad ? ST_FIN : ST_SCAN;
        end
      end

      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          // strict compares keep the lowest index on ties
          if (cnt_r == CNT_W'(1) || best_m_r < rd_mine) begin
            best_m_nxt = rd_mine;
            best_o_nxt = rd_other;
          end
          if (cnt_r == CNT_W'(1) || best_s_r < vsum) begin
            best_s_nxt = vsum;
            gs_nxt     = j;
          end
        end
        if (cnt_r == CNT_W'(ACTIONS)) begin
          state_nxt = ST_CUR;
        end
      end

      ST_CUR: begin
        cur_nxt   = rd_mine;
        base_nxt  = $signed({item_r.reward_value[VAL_W-1], item_r.reward_value, FRAC_W'(0)})
                  - TD_W'(rd_mine);
        state_nxt = ST_TD;
      end

      ST_TD: begin
        // gamma term floored by 2^16
        td_nxt    = base_r + TD_W'($signed(prod[MUL_P_W-1:FRAC_W]));
        state_nxt = ST_MLO;
      end

      ST_MLO: begin
        state_nxt = ST_MHI;
      end

      ST_MHI: begin
        acc_lo_nxt = prod[LOP_W-1:0];
        state_nxt  = ST_ACC;
      end

      ST_ACC: begin
        step_nxt  = sum[SUM_W-1:FRAC_W];
        state_nxt = ST_SAT;
      end

      ST_SAT: begin
        if (nv_full[NV_W-1:VAL_W-1] == {(NV_W-VAL_W+1){nv_full[NV_W-1]}}) begin
          nv_nxt = nv_full[VAL_W-1:0];
        end else begin
          nv_nxt = nv_full[NV_W-1] ? VAL_MIN : VAL_MAX;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (fire) begin
          out_nxt.updated_value      = err_r ? '0 : nv_r;
          out_nxt.next_greedy_action = err_r ? '0 : ACT_W'(gs_r);
          out_nxt.range_error        = err_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    err_r      <= err_nxt;
    nxt_base_r <= nxt_base_nxt;
    cur_addr_r <= cur_addr_nxt;
    best_m_r   <= best_m_nxt;
    best_o_r   <= best_o_nxt;
    best_s_r   <= best_s_nxt;
    gs_r       <= gs_nxt;
    cur_r      <= cur_nxt;
    base_r     <= base_nxt;
    td_r       <= td_nxt;
    acc_lo_r   <= acc_lo_nxt;
    step_r     <= step_nxt;
    nv_r       <= nv_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside the hand-over state");

  a_write_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    (wr0 || wr1) |-> (state_r == ST_CLEAR || state_r == ST_FIN))
    else $error("store written outside clearing or write-back");

  a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.range_error) |->
      (out_r.updated_value == '0 && out_r.next_greedy_action == '0))
    else $error("range error result carries a value");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN || state_r == ST_FIN))
    else $error("accepted transaction did not start");

  a_single_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> !(wr0 && wr1))
    else $error("write-back hit both stores");
`endif

endmodule
